>>> rtl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and command codes for the frustum sphere culling block.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_TEST    = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam int PLANE_W = 48;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         column_index;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] value_d;
    } item_t;

    // one normalized plane coefficient headed for the plane store
    typedef struct packed {
        logic               valid;
        logic [4:0]         index;
        logic [PLANE_W-1:0] value;
    } coef_wr_t;

endpackage

>>> rtl/fsc_fifo.sv
// ----------------------------------------------------------------------------
// fsc_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module fsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/fsc_front.sv
// ----------------------------------------------------------------------------
// fsc_front
// Accepts input words, drops the unused command and queues the rest.
// ----------------------------------------------------------------------------
module fsc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  fsc_pkg::item_t in_item,
    output fsc_pkg::item_t q_item,
    output logic          q_valid,
    input  logic          q_pop
);

    localparam int IW = $bits(fsc_pkg::item_t);

    logic          enq;
    logic          q_empty;
    logic [IW-1:0] q_data;

    // the unused command code is taken but never queued
    assign enq = push && !full && (in_item.command != fsc_pkg::CMD_NONE);

    fsc_fifo #(
        .WIDTH (IW),
        .DEPTH (4)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (enq),
        .wr_data (in_item),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    assign q_item  = fsc_pkg::item_t'(q_data);
    assign q_valid = !q_empty;

endmodule

>>> rtl/fsc_extract.sv
// ----------------------------------------------------------------------------
// fsc_extract
// Builds the six planes from the matrix and normalizes them, one coefficient
// at a time, with a bit-serial square root and a restoring divider.
// ----------------------------------------------------------------------------
module fsc_extract #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [15:0][31:0]   mat,
    output fsc_pkg::coef_wr_t   wr,
    output logic                done
);

    localparam int NUMW = 32 + FRAC_BITS;
    localparam int NCW  = $clog2(NUMW + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_COEF  = 3'd1;
    localparam logic [2:0] ST_SQ    = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_DINIT = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    function automatic logic [1:0] plane_row(input logic [2:0] p);
        logic [1:0] r;
        unique case (p)
            3'd0, 3'd1: r = 2'd0;
            3'd2, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic plane_neg(input logic [2:0] p);
        return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [2:0]         plane_reg, plane_next;
    logic [1:0]         idx_reg, idx_next;
    logic signed [32:0] coef_reg [4];
    logic signed [32:0] coef_next [4];
    logic [63:0]        sq_reg, sq_next;
    logic [63:0]        s_reg, s_next;
    logic [63:0]        x_reg, x_next;
    logic [63:0]        res_reg, res_next;
    logic [63:0]        bit_reg, bit_next;
    logic [31:0]        rem_reg, rem_next;
    logic [NUMW-1:0]    num_reg, num_next;
    logic [NUMW-1:0]    quo_reg, quo_next;
    logic [NCW-1:0]     dcnt_reg, dcnt_next;

    logic [1:0]         row;
    logic signed [32:0] w_col [4];
    logic signed [32:0] r_col [4];
    logic [32:0]        mag_sel;
    logic [31:0]        hi;
    logic [32:0]        hi_lo;
    logic [64:0]        sq_full;
    logic [63:0]        trial;
    logic [32:0]        rem_sh;
    logic               qbit;
    logic [63:0]        q64;
    logic [63:0]        neg64;
    logic [47:0]        sat_val;

    always_comb
    begin
        row = plane_row(plane_reg);
        for (int i = 0; i < 4; i++)
        begin
            w_col[i] = 33'($signed(mat[4 * i + 3]));
            r_col[i] = 33'($signed(mat[4 * i + int'(row)]));
        end
        mag_sel = mag33(coef_reg[idx_reg]);
        hi      = mag_sel[32:1];
        hi_lo   = {1'b0, hi} + {32'b0, mag_sel[0]};
        sq_full = 65'(hi) * 65'(hi_lo);
        trial   = res_reg + bit_reg;
        rem_sh  = {rem_reg, num_reg[NUMW-1]};
        qbit    = (rem_sh >= {1'b0, res_reg[31:0]});
        q64     = 64'(quo_reg);
        neg64   = 64'd0 - q64;
        if (coef_reg[idx_reg][32])
        begin
            sat_val = (q64 > 64'h0000_8000_0000_0000) ? 48'h8000_0000_0000 : neg64[47:0];
        end
        else
        begin
            sat_val = (q64 > 64'h0000_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q64[47:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        idx_next   = idx_reg;
        coef_next  = coef_reg;
        sq_next    = sq_reg;
        s_next     = s_reg;
        x_next     = x_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        wr         = '0;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    plane_next = '0;
                    state_next = ST_COEF;
                end
            end
            ST_COEF:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    coef_next[i] = plane_neg(plane_reg) ? w_col[i] - r_col[i]
                                                        : w_col[i] + r_col[i];
                end
                idx_next   = '0;
                s_next     = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                // quarter squares of the first three coefficients, each summed in the following cycle
                sq_next = sq_full[63:0];
                if (idx_reg != 2'd0)
                begin
                    s_next = s_reg + sq_reg;
                end
                if (idx_reg == 2'd3)
                begin
                    x_next     = s_reg + sq_reg;
                    res_next   = '0;
                    bit_next   = 64'h4000_0000_0000_0000;
                    state_next = ST_SQRT;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_SQRT:
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    idx_next   = '0;
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT:
            begin
                num_next   = NUMW'(mag_sel) << (FRAC_BITS - 1);
                rem_next   = '0;
                quo_next   = '0;
                dcnt_next  = NCW'(NUMW);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = qbit ? 32'(rem_sh - {1'b0, res_reg[31:0]}) : rem_sh[31:0];
                quo_next  = {quo_reg[NUMW-2:0], qbit};
                num_next  = num_reg << 1;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == NCW'(1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                wr.valid = 1'b1;
                wr.index = {plane_reg, idx_reg};
                // a degenerate normal leaves the whole plane at zero
                wr.value = (res_reg[31:0] == '0) ? '0 : sat_val;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 2'd3)
                begin
                    if (plane_reg == 3'd5)
                    begin
                        done       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                        state_next = ST_COEF;
                    end
                end
                else
                begin
                    state_next = ST_DINIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            idx_reg   <= idx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        sq_reg   <= sq_next;
        s_reg    <= s_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
    end

endmodule

>>> rtl/fsc_back.sv
// ----------------------------------------------------------------------------
// fsc_back
// Carries out queued commands: matrix loads, plane extraction and the
// pipelined six-plane sphere test.
// ----------------------------------------------------------------------------
module fsc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  fsc_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_pop,
    input  logic [2:0]     radius_scale,
    input  logic           res_full,
    output logic           res_push,
    output logic           res_outside
);

    localparam int NW = FRAC_BITS + 2;
    localparam int PW = NW + 32;
    localparam int SW = PW + 2;
    localparam int DW = ((SW > fsc_pkg::PLANE_W) ? SW : fsc_pkg::PLANE_W) + 1;
    localparam logic signed [DW-1:0] D_MAX = DW'($signed(48'h7FFF_FFFF_FFFF));
    localparam logic signed [DW-1:0] D_MIN = DW'($signed(48'h8000_0000_0000));

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_EXT  = 2'd1;
    localparam logic [1:0] B_TEST = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [15:0][31:0]         mat_reg;
    logic [fsc_pkg::PLANE_W-1:0] plane_reg [24];

    logic signed [31:0]        cx_reg, cy_reg, cz_reg;
    logic signed [36:0]        thr_reg;
    logic [2:0]                tp_reg;
    logic                      issue_reg;
    logic signed [PW-1:0]      prod_reg [3];
    logic                      pv_reg, sv_reg, dv_reg;
    logic [2:0]                pp_reg, sp_reg, dp_reg;
    logic signed [SW-1:0]      sum_reg;
    logic signed [47:0]        d_reg;
    logic                      out_acc_reg;

    logic                      ext_start;
    logic                      ext_done;
    fsc_pkg::coef_wr_t         ext_wr;
    logic                      start_test;
    logic signed [NW-1:0]      n_sel [3];
    logic signed [SW-1:0]      sum_sh;
    logic signed [DW-1:0]      dsum;
    logic signed [47:0]        d_sat;
    logic                      cmp;
    logic signed [35:0]        scale_prod;

    fsc_extract #(
        .FRAC_BITS (FRAC_BITS)
    ) u_extract (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ext_start),
        .mat   (mat_reg),
        .wr    (ext_wr),
        .done  (ext_done)
    );

    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        ext_start  = 1'b0;
        start_test = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.command)
                        fsc_pkg::CMD_EXTRACT:
                        begin
                            item_pop   = 1'b1;
                            ext_start  = 1'b1;
                            state_next = B_EXT;
                        end
                        fsc_pkg::CMD_TEST:
                        begin
                            // one result slot is free for the whole test
                            if (!res_full)
                            begin
                                item_pop   = 1'b1;
                                start_test = 1'b1;
                                state_next = B_TEST;
                            end
                        end
                        default:
                        begin
                            item_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_EXT:
            begin
                if (ext_done)
                begin
                    state_next = B_IDLE;
                end
            end
            B_TEST:
            begin
                if (dv_reg && (dp_reg == 3'd5))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_sel[i] = $signed(plane_reg[{tp_reg, 2'(i)}][NW-1:0]);
        end
        sum_sh = sum_reg >>> FRAC_BITS;
        dsum   = DW'(sum_sh) + DW'($signed(plane_reg[{sp_reg, 2'd3}]));
        if (dsum > D_MAX)
        begin
            d_sat = 48'sh7FFF_FFFF_FFFF;
        end
        else if (dsum < D_MIN)
        begin
            d_sat = $signed(48'h8000_0000_0000);
        end
        else
        begin
            d_sat = dsum[47:0];
        end
        cmp        = (49'(d_reg) < 49'(thr_reg));
        scale_prod = 36'($signed({1'b0, radius_scale})) * 36'(item.value_d);
    end

    assign res_push    = dv_reg && (dp_reg == 3'd5);
    assign res_outside = out_acc_reg || cmp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            mat_reg     <= '0;
            for (int i = 0; i < 24; i++)
            begin
                plane_reg[i] <= '0;
            end
            issue_reg   <= 1'b0;
            tp_reg      <= '0;
            pv_reg      <= 1'b0;
            sv_reg      <= 1'b0;
            dv_reg      <= 1'b0;
            pp_reg      <= '0;
            sp_reg      <= '0;
            dp_reg      <= '0;
            out_acc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && item_valid && item.command == fsc_pkg::CMD_LOAD)
            begin
                mat_reg[{item.column_index, 2'd0}] <= item.value_a;
                mat_reg[{item.column_index, 2'd1}] <= item.value_b;
                mat_reg[{item.column_index, 2'd2}] <= item.value_c;
                mat_reg[{item.column_index, 2'd3}] <= item.value_d;
            end
            if (ext_wr.valid)
            begin
                plane_reg[ext_wr.index] <= ext_wr.value;
            end
            if (start_test)
            begin
                issue_reg   <= 1'b1;
                tp_reg      <= '0;
                out_acc_reg <= 1'b0;
            end
            else if (issue_reg)
            begin
                tp_reg <= tp_reg + 1'b1;
                if (tp_reg == 3'd5)
                begin
                    issue_reg <= 1'b0;
                end
            end
            pv_reg <= issue_reg;
            pp_reg <= tp_reg;
            sv_reg <= pv_reg;
            sp_reg <= pp_reg;
            dv_reg <= sv_reg;
            dp_reg <= sp_reg;
            if (dv_reg)
            begin
                out_acc_reg <= out_acc_reg || cmp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_test)
        begin
            cx_reg  <= item.value_a;
            cy_reg  <= item.value_b;
            cz_reg  <= item.value_c;
            thr_reg <= 37'sd0 - 37'(scale_prod);
        end
        prod_reg[0] <= PW'(n_sel[0]) * PW'(cx_reg);
        prod_reg[1] <= PW'(n_sel[1]) * PW'(cy_reg);
        prod_reg[2] <= PW'(n_sel[2]) * PW'(cz_reg);
        sum_reg     <= SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        d_reg       <= d_sat;
    end

    a_ext_done_in_ext: assert property (@(posedge clk) disable iff (!rst_n)
        ext_done |-> (state_reg == B_EXT))
        else $error("plane extraction finished outside its state");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE) |-> !(pv_reg || sv_reg || dv_reg || issue_reg))
        else $error("test pipeline busy while idle");

    a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start_test |=> (state_reg == B_TEST) && issue_reg && (tp_reg == 3'd0))
        else $error("sphere test did not start");

endmodule

>>> rtl/frustum_sphere_cull.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull
// Sphere against view frustum culling with planes taken from the combined
// view-projection matrix, in signed fixed point.
// ----------------------------------------------------------------------------
// Input words are written with push while full is low. command 0 loads one
// matrix column (value_a..value_d = rows 0..3), 1 extracts and normalizes the
// six planes, 2 tests a sphere (centre value_a..value_c, radius value_d).
// Only a test gives a result word; it shows on outside while empty is low and
// is taken with pop. radius_scale is written over the cfg_valid/cfg_ready
// channel, which is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce. A four-word command queue
// sits between the front end and the execution unit, so input words keep being
// taken while a result waits to be popped. In the execution unit a test makes
// a six-plane pass through three multipliers and a three-stage distance
// pipeline, and the next command waits until that test's result is pushed.
// An extract is paced by the bit-serial square root and the one-bit-a-cycle
// divider. A test waits while the two-word result queue is full. Reset clears
// the matrix, the planes and both queues, and sets radius_scale to 2.
// ----------------------------------------------------------------------------
module frustum_sphere_cull #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         command,
    input  logic [1:0]         column_index,
    input  logic signed [31:0] value_a,
    input  logic signed [31:0] value_b,
    input  logic signed [31:0] value_c,
    input  logic signed [31:0] value_d,
    output logic               empty,
    input  logic               pop,
    output logic               outside,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         radius_scale
);

    fsc_pkg::item_t in_item;
    fsc_pkg::item_t q_item;
    logic           q_valid;
    logic           q_pop;
    logic           res_full;
    logic           res_push;
    logic           res_outside;
    logic [2:0]     scale_reg;

    assign in_item.command      = command;
    assign in_item.column_index = column_index;
    assign in_item.value_a      = value_a;
    assign in_item.value_b      = value_b;
    assign in_item.value_c      = value_c;
    assign in_item.value_d      = value_d;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= radius_scale;
        end
    end

    fsc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    fsc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (q_item),
        .item_valid   (q_valid),
        .item_pop     (q_pop),
        .radius_scale (scale_reg),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_outside  (res_outside)
    );

    fsc_fifo #(
        .WIDTH (1),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_outside),
        .rd_en   (pop),
        .rd_data (outside),
        .full    (res_full),
        .empty   (empty)
    );

endmodule

>>> sim/tb_frustum_sphere_cull.sv
// ----------------------------------------------------------------------------
// tb_frustum_sphere_cull
// Self-checking bench for the frustum sphere culling block: matrix loads,
// plane extraction and sphere tests are predicted in the bench and each
// result word is compared against the oldest prediction, under random gaps
// on both queue sides and radius_scale settings 2, 1, 4, 0 and 7.
// ----------------------------------------------------------------------------
module tb_frustum_sphere_cull;

    localparam int FB = 16;
    localparam longint PL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint PL_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;
    localparam int IDLE_WAIT = 8000;
    localparam int CYCLE_LIMIT = 1500000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         command = fsc_pkg::CMD_NONE;
    logic [1:0]         column_index = 2'd0;
    logic signed [31:0] value_a = '0;
    logic signed [31:0] value_b = '0;
    logic signed [31:0] value_c = '0;
    logic signed [31:0] value_d = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               outside;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         radius_scale = 3'd2;

    frustum_sphere_cull #(.FRAC_BITS(FB)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [31:0]        mat_mirror [16];
    logic signed [47:0] plane_mirror [24];
    logic [2:0]         scale_mirror;
    bit                 cull_q [$];

    int errors = 0;
    int n_tests = 0;
    int n_culled = 0;
    int n_words = 0;
    longint cycles = 0;
    int rx_hold = 0;
    bit tx_fast = 1'b0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint sat_plane(input logic signed [95:0] v);
        if (v > PL_MAX) return PL_MAX;
        if (v < PL_MIN) return PL_MIN;
        return longint'(v);
    endfunction

    function automatic void build_planes();
        longint coef [4];
        longint unsigned mag, hi, lo, s, h, q;
        int row;
        bit neg;
        for (int p = 0; p < 6; p++)
        begin
            row = p / 2;
            neg = (p == 1 || p == 2 || p == 5);
            for (int i = 0; i < 4; i++)
            begin
                coef[i] = neg
                    ? longint'($signed(mat_mirror[i*4+3])) - longint'($signed(mat_mirror[i*4+row]))
                    : longint'($signed(mat_mirror[i*4+3])) + longint'($signed(mat_mirror[i*4+row]));
            end
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag = coef[i] < 0 ? -coef[i] : coef[i];
                hi = mag >> 1;
                lo = mag & 1;
                s = s + hi * hi + hi * lo;
            end
            h = isqrt(s);
            for (int i = 0; i < 4; i++)
            begin
                if (h == 0)
                    plane_mirror[p*4+i] = '0;
                else
                begin
                    mag = coef[i] < 0 ? -coef[i] : coef[i];
                    q = (mag << (FB - 1)) / h;
                    plane_mirror[p*4+i] = 48'(sat_plane(coef[i] < 0 ? -96'sd1 * $signed({1'b0, q})
                                                                    : $signed({1'b0, q})));
                end
            end
        end
    endfunction

    function automatic bit sphere_culled(input logic signed [31:0] x, y, z, r);
        logic signed [95:0] acc;
        longint d, thr;
        bit cull;
        cull = 1'b0;
        thr = -(longint'(scale_mirror) * longint'(r));
        for (int p = 0; p < 6; p++)
        begin
            acc = 96'(plane_mirror[p*4]) * 96'(x) + 96'(plane_mirror[p*4+1]) * 96'(y)
                + 96'(plane_mirror[p*4+2]) * 96'(z);
            d = sat_plane((acc >>> FB) + 96'(plane_mirror[p*4+3]));
            if (d < thr) cull = 1'b1;
        end
        return cull;
    endfunction

    // sends one word and updates the predictor when it is taken
    task automatic send_word(input logic [1:0] cmd, input logic [1:0] col,
                             input logic [31:0] a, b, c, d);
        int gap;
        gap = tx_fast ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        command <= cmd;
        column_index <= col;
        value_a <= a;
        value_b <= b;
        value_c <= c;
        value_d <= d;
        do @(posedge clk); while (full);
        n_words++;
        case (cmd)
            fsc_pkg::CMD_LOAD:
            begin
                mat_mirror[col*4+0] = a;
                mat_mirror[col*4+1] = b;
                mat_mirror[col*4+2] = c;
                mat_mirror[col*4+3] = d;
            end
            fsc_pkg::CMD_EXTRACT: build_planes();
            fsc_pkg::CMD_TEST:
            begin
                cull_q.push_back(sphere_culled(a, b, c, d));
                n_tests++;
            end
            default: ;
        endcase
    endtask

    task automatic drain_and_idle();
        push <= 1'b0;
        @(posedge clk);
        while (cull_q.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_scale(input logic [2:0] v);
        drain_and_idle();
        cfg_valid <= 1'b1;
        radius_scale <= v;
        do @(posedge clk); while (!cfg_ready);
        scale_mirror = v;
        cfg_valid <= 1'b0;
    endtask

    // result side: random gaps, one optional long hold
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (rx_hold > 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            if (cull_q.size() == 0)
            begin
                $error("unexpected result word, outside=%0b", outside);
                errors++;
            end
            else
            begin
                if (outside !== cull_q[0])
                begin
                    $error("outside: expected %0b actual %0b", cull_q[0], outside);
                    errors++;
                end
                if (cull_q[0]) n_culled++;
                void'(cull_q.pop_front());
            end
        end
    end

    function automatic logic [31:0] edge_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // moderate Q16.16 value in +-range units
    function automatic logic [31:0] fx(input int range);
        return 32'($signed($urandom_range(0, 2 * range * 65536)) - range * 65536);
    endfunction

    task automatic test_directed();
        // zero planes: culled only when the threshold goes positive
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_0000);
        send_word(fsc_pkg::CMD_TEST, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_word(fsc_pkg::CMD_NONE, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        // degenerate normal from an all zero matrix
        send_word(fsc_pkg::CMD_EXTRACT, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000);
        // identity-like matrix
        send_word(fsc_pkg::CMD_LOAD, 2'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        send_word(fsc_pkg::CMD_LOAD, 2'd1, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        send_word(fsc_pkg::CMD_LOAD, 2'd2, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
        send_word(fsc_pkg::CMD_LOAD, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0001_0000);
        send_word(fsc_pkg::CMD_EXTRACT, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0000_8000);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0001_0000);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF);
        // extreme matrix entries drive saturation
        for (int i = 0; i < 4; i++)
            send_word(fsc_pkg::CMD_LOAD, 2'(i), 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      (i == 3) ? 32'h8000_0000 : 32'h0000_0001);
        send_word(fsc_pkg::CMD_EXTRACT, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_word(fsc_pkg::CMD_TEST, 2'd0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000);
    endtask

    task automatic test_random(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // well formed: full matrix, extract, batch of spheres
                for (int i = 0; i < 4; i++)
                    send_word(fsc_pkg::CMD_LOAD, 2'(i), fx(2), fx(2), fx(2), fx(2));
                send_word(fsc_pkg::CMD_EXTRACT, 2'($urandom), $urandom, $urandom, $urandom,
                          $urandom);
                sent += 5;
                repeat ($urandom_range(20, 60))
                begin
                    send_word(fsc_pkg::CMD_TEST, 2'($urandom), fx(8), fx(8), fx(8), fx(3));
                    sent++;
                end
            end
            else
            begin
                repeat ($urandom_range(5, 20))
                begin
                    send_word(2'($urandom), 2'($urandom), edge_val(), edge_val(),
                              edge_val(), edge_val());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        tx_fast = 1'b1;
        repeat (40) send_word(fsc_pkg::CMD_TEST, 2'd0, fx(8), fx(8), fx(8), fx(3));
        tx_fast = 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++) mat_mirror[i] = '0;
        for (int i = 0; i < 24; i++) plane_mirror[i] = '0;
        scale_mirror = 3'd2;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        write_scale(3'd1);
        test_random(350);
        write_scale(3'd4);
        test_random(350);
        write_scale(3'd0);
        test_directed();
        test_random(250);
        write_scale(3'd7);
        test_random(300);
        write_scale(3'd2);
        test_random(300);
        drain_and_idle();
        $display("%0d words sent, %0d sphere tests checked (%0d culled)",
                 n_words, n_tests, n_culled);
        $display("radius_scale settings 2, 1, 4, 0, 7 with a long result stall");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
